### rtl/core/box_filter_3x3_stream_macros.svh
// Assertion macros for the 3x3 box filter.
// Both expect the enclosing module to have clock and reset in scope.
`ifndef BOX_FILTER_3X3_STREAM_MACROS_SVH
`define BOX_FILTER_3X3_STREAM_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define BF3_CHECK(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define BF3_CHECK_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/bf3_pkg.sv
`default_nettype none

package bf3_pkg;

   localparam int MAX_WIDTH     = 1024;
   localparam int COL_BITS      = $clog2(MAX_WIDTH);
   localparam int WIDTH_BITS    = 11;
   localparam int SAMPLE_BITS   = 16;
   localparam int LINE_BITS     = 2 * SAMPLE_BITS;
   localparam int COLSUM_BITS   = SAMPLE_BITS + 2;
   localparam int SUM_BITS      = SAMPLE_BITS + 4;
   localparam int PROD_BITS     = 2 * SUM_BITS;

   // floor(s/9) = floor((s + 9*2^15) * RECIP_9 >> 23) - 2^15
   localparam logic [SUM_BITS-1:0] DIV_OFFSET = SUM_BITS'(9 * 32768);
   localparam logic [SUM_BITS-1:0] RECIP_9    = SUM_BITS'(932068);
   localparam int RECIP_SHIFT = 23;

   // output queue
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = QPTR_BITS + 1;

   // configuration port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [0:0] REG_IMAGE_WIDTH = 1'b0;
   localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(3);

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          frame_start;
   } req_word_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] mean;
      logic                          last;
   } rsp_word_type;

   // per-item control that rides along the pipeline
   typedef struct packed {
      logic emit;
      logic last;
   } ctrl_type;

   // clamp the programmed width into 3..MAX_WIDTH
   function automatic logic [WIDTH_BITS-1:0] clamp_width(input logic [WIDTH_BITS-1:0] w);
      logic [WIDTH_BITS-1:0] r;
      if (w < WIDTH_BITS'(3)) begin
         r = WIDTH_BITS'(3);
      end else if (w > WIDTH_BITS'(MAX_WIDTH)) begin
         r = WIDTH_BITS'(MAX_WIDTH);
      end else begin
         r = w;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/core/bf3_ram.sv
`default_nettype none

module bf3_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port, registered read (old data on collision)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### rtl/core/bf3_lines.sv
`default_nettype none

module bf3_lines
   import bf3_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic [COL_BITS-1:0]           in_addr,
   input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
   input  wire ctrl_type                      in_ctrl,
   output logic                               out_valid,
   output logic [SUM_BITS-1:0]                out_biased_sum,
   output ctrl_type                           out_ctrl
);

   logic                          p1_valid_ff;
   logic [COL_BITS-1:0]           p1_addr_ff;
   logic signed [SAMPLE_BITS-1:0] p1_sample_ff;
   ctrl_type                      p1_ctrl_ff;
   logic                          fwd_hit_ff;
   logic [LINE_BITS-1:0]          fwd_data_ff;
   logic [LINE_BITS-1:0]          rd_data;
   logic [LINE_BITS-1:0]          lines;
   logic [LINE_BITS-1:0]          wr_data;
   logic signed [SAMPLE_BITS-1:0] upper;
   logic signed [SAMPLE_BITS-1:0] middle;
   logic signed [COLSUM_BITS-1:0] colsum;
   logic signed [COLSUM_BITS-1:0] c0_ff;
   logic signed [COLSUM_BITS-1:0] c1_ff;
   logic signed [COLSUM_BITS-1:0] c2_ff;
   logic                          p2_valid_ff;
   ctrl_type                      p2_ctrl_ff;
   logic [SUM_BITS-1:0]           wsum;
   logic                          p3_valid_ff;
   ctrl_type                      p3_ctrl_ff;
   logic [SUM_BITS-1:0]           p3_sum_ff;

   // both line buffers share one word: upper row high, middle row low
   bf3_ram #(
      .WIDTH (LINE_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (p1_valid_ff),
      .wr_addr (p1_addr_ff),
      .wr_data (wr_data),
      .rd_addr (in_addr),
      .rd_data (rd_data)
   );

   // bypass the RAM when the previous word wrote the column being read
   assign lines   = fwd_hit_ff ? fwd_data_ff : rd_data;
   assign upper   = lines[LINE_BITS-1:SAMPLE_BITS];
   assign middle  = lines[SAMPLE_BITS-1:0];
   assign wr_data = {middle, p1_sample_ff};

   // sum the new column of the window
   assign colsum = COLSUM_BITS'(upper) + COLSUM_BITS'(middle) + COLSUM_BITS'(p1_sample_ff);

   // sum the three columns, biased to non-negative
   assign wsum = SUM_BITS'(c0_ff) + SUM_BITS'(c1_ff) + SUM_BITS'(c2_ff) + DIV_OFFSET;

   // control of the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         p1_valid_ff <= in_valid;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
         fwd_hit_ff  <= in_valid && p1_valid_ff && (in_addr == p1_addr_ff);
      end
   end

   // payload of the stages
   always_ff @(posedge clock) begin
      fwd_data_ff <= wr_data;
      if (in_valid) begin
         p1_addr_ff   <= in_addr;
         p1_sample_ff <= in_sample;
         p1_ctrl_ff   <= in_ctrl;
      end
      // shift the window one column left
      if (p1_valid_ff) begin
         c0_ff <= c1_ff;
         c1_ff <= c2_ff;
         c2_ff <= colsum;
      end
      p2_ctrl_ff <= p1_ctrl_ff;
      p3_ctrl_ff <= p2_ctrl_ff;
      p3_sum_ff  <= wsum;
   end

   assign out_valid      = p3_valid_ff;
   assign out_biased_sum = p3_sum_ff;
   assign out_ctrl       = p3_ctrl_ff;

endmodule

`default_nettype wire

### rtl/core/bf3_mean.sv
`default_nettype none

module bf3_mean
   import bf3_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic [SUM_BITS-1:0]  in_biased_sum,
   input  wire ctrl_type             in_ctrl,
   output logic                      done,
   output logic                      out_valid,
   output rsp_word_type              out_word
);

   logic [PROD_BITS-1:0]   prod;
   logic                   valid_ff;
   ctrl_type               ctrl_ff;
   logic [SAMPLE_BITS-1:0] quot_ff;

   // divide by nine through the reciprocal
   assign prod = PROD_BITS'(in_biased_sum) * PROD_BITS'(RECIP_9);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      ctrl_ff <= in_ctrl;
      quot_ff <= prod[RECIP_SHIFT+SAMPLE_BITS-1:RECIP_SHIFT];
   end

   // remove the bias: subtract 2^15 by flipping the top bit
   assign done          = valid_ff;
   assign out_valid     = valid_ff && ctrl_ff.emit;
   assign out_word.mean = {~quot_ff[SAMPLE_BITS-1], quot_ff[SAMPLE_BITS-2:0]};
   assign out_word.last = ctrl_ff.last;

endmodule

`default_nettype wire

### rtl/core/bf3_queue.sv
`default_nettype none

module bf3_queue
   import bf3_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire rsp_word_type   push_word,
   input  wire logic           pop,
   output logic                out_valid,
   output rsp_word_type        out_word,
   output logic [QCNT_BITS-1:0] count
);

   rsp_word_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff;
   logic [QPTR_BITS-1:0]  rd_ptr_ff;
   logic [QCNT_BITS-1:0]  count_ff;
   logic [QCNT_BITS-1:0]  count_in;

   assign count_in = count_ff + QCNT_BITS'(push) - QCNT_BITS'(pop);

   // advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_BITS'(1);
         end
         count_ff <= count_in;
      end
   end

   // store the word
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_word  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

`default_nettype wire

### rtl/core/box_filter_3x3_stream.sv
// 3x3 box filter over a square image streamed one signed Q8.8 sample per word in raster
// order. image_width (register 0, byte address 0, reset 3, clamped to 3..1024) sets the
// side. Each sample at row >= 2 and column >= 2 yields one word holding the floor of the
// mean of the 3x3 window that ends there; last marks the bottom-right window. A sample
// with frame_start restarts at row 0, column 0; after the bottom-right sample the next
// one starts a new frame on its own. The block takes one sample per clock, sustained while
// req_stall is low: the two line buffers live in one RAM that is read and written once per
// cycle, with a bypass for back-to-back hits on one column. An eight-word output queue
// absorbs rsp_stall, and req_stall rises only in reset or when that queue plus the words
// in flight would overflow it. Rows read before they were ever written (only after a
// width change inside a frame) return unspecified data.
`default_nettype none

`include "box_filter_3x3_stream_macros.svh"

module box_filter_3x3_stream
   import bf3_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire req_word_type             req_word,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output rsp_word_type                  rsp_word,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]      csr_prdata,
   output logic                          csr_pready
);

   logic [WIDTH_BITS-1:0] width_ff;
   logic [WIDTH_BITS-1:0] eff_width;
   logic [0:0]            csr_index;
   logic                  csr_write;
   logic [COL_BITS-1:0]   row_ff;
   logic [COL_BITS-1:0]   col_ff;
   logic [COL_BITS-1:0]   row_in;
   logic [COL_BITS-1:0]   col_in;
   logic [COL_BITS-1:0]   row_cur;
   logic [COL_BITS-1:0]   col_cur;
   logic [WIDTH_BITS-1:0] row_next;
   logic [WIDTH_BITS-1:0] col_next;
   logic                  accept;
   ctrl_type              in_ctrl;
   logic                  sum_valid;
   logic [SUM_BITS-1:0]   biased_sum;
   ctrl_type              sum_ctrl;
   logic                  mean_done;
   logic                  mean_valid;
   rsp_word_type          mean_word;
   logic [QCNT_BITS-1:0]  queue_count;
   logic [QCNT_BITS-1:0]  pend_ff;
   logic [QCNT_BITS-1:0]  pend_in;
   logic                  pop;

   // configuration port
   assign csr_index  = csr_paddr[CSR_ADDR_BITS-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_index == REG_IMAGE_WIDTH) ?
                       CSR_DATA_BITS'(width_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
      end else if (csr_write && (csr_index == REG_IMAGE_WIDTH)) begin
         width_ff <= csr_pwdata[WIDTH_BITS-1:0];
      end
   end

   assign eff_width = clamp_width(width_ff);

   // hold off input in reset and while the queue could not take one more word beyond those in flight
   assign req_stall = reset || ((pend_ff + queue_count) >= QCNT_BITS'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;

   // raster position of this word
   assign row_cur  = req_word.frame_start ? '0 : row_ff;
   assign col_cur  = req_word.frame_start ? '0 : col_ff;
   assign row_next = WIDTH_BITS'(row_cur) + WIDTH_BITS'(1);
   assign col_next = WIDTH_BITS'(col_cur) + WIDTH_BITS'(1);

   assign in_ctrl.emit = (row_cur >= COL_BITS'(2)) && (col_cur >= COL_BITS'(2));
   assign in_ctrl.last = (row_next == eff_width) && (col_next == eff_width);

   always_comb begin
      row_in = row_cur;
      col_in = col_next[COL_BITS-1:0];
      if (col_next >= eff_width) begin
         col_in = '0;
         row_in = (row_next >= eff_width) ? '0 : row_next[COL_BITS-1:0];
      end
   end

   // advance the raster counters and count words in flight
   assign pend_in = pend_ff + QCNT_BITS'(accept) - QCNT_BITS'(mean_done);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         pend_ff <= '0;
      end else begin
         if (accept) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
         pend_ff <= pend_in;
      end
   end

   bf3_lines u_lines (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (accept),
      .in_addr        (col_cur),
      .in_sample      (req_word.sample),
      .in_ctrl        (in_ctrl),
      .out_valid      (sum_valid),
      .out_biased_sum (biased_sum),
      .out_ctrl       (sum_ctrl)
   );

   bf3_mean u_mean (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (sum_valid),
      .in_biased_sum (biased_sum),
      .in_ctrl       (sum_ctrl),
      .done          (mean_done),
      .out_valid     (mean_valid),
      .out_word      (mean_word)
   );

   bf3_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mean_valid),
      .push_word (mean_word),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_word  (rsp_word),
      .count     (queue_count)
   );

   // checks
   `BF3_CHECK(a_credit_bound,
      (pend_ff + queue_count) <= QCNT_BITS'(QUEUE_DEPTH),
      "queue credit overrun")
   `BF3_CHECK(a_push_room,
      !mean_valid || (queue_count < QCNT_BITS'(QUEUE_DEPTH)) || pop,
      "push into full queue")
   `BF3_CHECK_NEXT(a_frame_restart,
      accept && req_word.frame_start,
      (row_ff == '0) && (col_ff == COL_BITS'(1)),
      "frame start did not restart raster")

endmodule

`default_nettype wire

### tb/sv/tb_box_filter_3x3_stream.sv
`timescale 1ns / 1ps

module tb_box_filter_3x3_stream;
   import bf3_pkg::*;

   localparam int DRAIN_CYCLES     = 12;
   localparam int WATCHDOG_LIMIT   = 3000;
   localparam int HOLD_CYCLES      = 300;
   localparam int RANDOM_PER_PHASE = 40;
   localparam logic [CSR_ADDR_BITS-1:0] WIDTH_ADDR =
      CSR_ADDR_BITS'(4 * int'(REG_IMAGE_WIDTH));

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_stall;
   req_word_type             req_word    = '0;
   logic                     rsp_valid;
   logic                     rsp_stall   = 1'b0;
   rsp_word_type             rsp_word;
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   // filter state as the testbench sees it
   logic [WIDTH_BITS-1:0]         width_reg = WIDTH_RESET;
   logic signed [SAMPLE_BITS-1:0] upper_row [MAX_WIDTH];
   logic signed [SAMPLE_BITS-1:0] middle_row [MAX_WIDTH];
   logic signed [SAMPLE_BITS-1:0] win [9];
   int unsigned                   row_pos = 0;
   int unsigned                   col_pos = 0;
   rsp_word_type                  pending_means [$];

   // traffic shaping and bookkeeping
   int unsigned send_gap_pct       = 0;
   int unsigned rsp_stall_pct      = 0;
   int unsigned hold_ticket        = 0;
   int unsigned hold_taken         = 0;
   int unsigned hold_left          = 0;
   int unsigned quiet_cycles       = 0;
   int unsigned mismatch_count     = 0;
   int unsigned samples_sent       = 0;
   int unsigned means_checked      = 0;
   int unsigned input_stall_cycles = 0;

   box_filter_3x3_stream uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // programmed width, pulled into the legal range
   function automatic int unsigned active_width();
      if (width_reg < 3) return 3;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
   endfunction

   // shift one sample into the window and queue the mean it produces
   function automatic void advance_window(input req_word_type w);
      int unsigned  cw;
      int unsigned  k;
      int           sum;
      int           quot;
      rsp_word_type m;
      cw = active_width();
      if (w.frame_start) begin
         row_pos = 0;
         col_pos = 0;
      end
      for (k = 0; k < 3; k++) begin
         win[k*3]   = win[k*3+1];
         win[k*3+1] = win[k*3+2];
      end
      win[2] = upper_row[col_pos];
      win[5] = middle_row[col_pos];
      win[8] = w.sample;
      upper_row[col_pos]  = middle_row[col_pos];
      middle_row[col_pos] = w.sample;
      if (row_pos >= 2 && col_pos >= 2) begin
         sum = 0;
         for (k = 0; k < 9; k++) sum += int'(win[k]);
         // divide rounding toward minus infinity
         quot = sum / 9;
         if ((sum % 9) != 0 && sum < 0) quot = quot - 1;
         m.mean = quot[SAMPLE_BITS-1:0];
         m.last = (row_pos == cw - 1) && (col_pos == cw - 1);
         pending_means.push_back(m);
      end
      // step the raster position, wrapping at the current width
      if (col_pos + 1 >= cw) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= cw) ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endfunction

   // near full scale, near negative full scale, or anything
   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input int unsigned flavor);
      case (flavor)
         0: begin
            return SAMPLE_BITS'($urandom_range(32767, 32512));
         end
         1: begin
            return SAMPLE_BITS'(32'h8000 + $urandom_range(255));
         end
         default: begin
            return SAMPLE_BITS'($urandom);
         end
      endcase
   endfunction

   // offer one sample word, hold it until accepted, then predict
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value, input logic start);
      req_word_type w;
      w.sample      = value;
      w.frame_start = start;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do begin
         @(posedge clock);
      end while (req_stall);
      advance_window(w);
      samples_sent++;
   endtask

   task automatic send_run(input int unsigned count, input int unsigned flavor,
                           input logic restart);
      int unsigned i;
      for (i = 0; i < count; i++) begin
         send_sample(pick_sample(flavor), restart && (i == 0));
      end
   endtask

   // drop valid, wait out every expected mean and the pipeline tail
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_means.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write image_width while idle, then read it back
   task automatic write_width(input logic [CSR_DATA_BITS-1:0] value);
      drain_results();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= WIDTH_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      width_reg = value[WIDTH_BITS-1:0];
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      if (csr_prdata !== CSR_DATA_BITS'(width_reg)) begin
         $error("image_width: expected %0d, got %0d", width_reg, csr_prdata);
         mismatch_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // full-scale windows, wrap into a new frame without the flag, floor of a negative sum
   task automatic test_extreme_samples();
      int unsigned i;
      send_gap_pct  = 36;
      rsp_stall_pct = 62;
      for (i = 0; i < 9; i++) send_sample(16'sh7FFF, i == 0);
      for (i = 0; i < 9; i++) send_sample(16'sh8000, 1'b0);
      for (i = 0; i < 9; i++) send_sample((i == 4) ? 16'shFFFF : 16'sh0000, i == 0);
      drain_results();
   endtask

   // widths below and above the legal range and junk upper bits
   task automatic test_width_limits();
      write_width(32'h0000_0000);
      send_run(9, 2, 1'b1);
      write_width(32'h1234_0004);
      send_run(16, 2, 1'b1);
      write_width(32'h0000_07FF);
      send_run(40, 2, 1'b1);
      drain_results();
   endtask

   // shrink the width inside a frame so column and row counts wrap
   task automatic test_width_shrink_mid_frame();
      int unsigned n;
      int unsigned target;
      send_gap_pct  = 36;
      rsp_stall_pct = 62;
      for (n = 0; n < 2; n++) begin
         target = (n == 0) ? 5 : 3;
         write_width(32'd8);
         // stop at row 3, column 7 of an 8-wide frame
         send_run(3 * 8 + 7, 2, 1'b1);
         write_width(CSR_DATA_BITS'(target));
         send_run(1 + target + 2 * target * target, 2, 1'b0);
      end
      drain_results();
   endtask

   // mostly whole frames with random content, some cut short or restarted
   task automatic test_random_frames();
      int unsigned phase;
      int unsigned cw;
      int unsigned len;
      int unsigned flavor;
      int unsigned sent;
      int unsigned i;
      logic        broke;
      logic        start;
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_gap_pct  = 36;
               rsp_stall_pct = 62;
            end
            1: begin
               send_gap_pct  = 62;
               rsp_stall_pct = 36;
            end
            default: begin
               send_gap_pct  = 0;
               rsp_stall_pct = 0;
            end
         endcase
         cw = ($urandom_range(4) == 0) ? $urandom_range(12, 10) : $urandom_range(9, 3);
         write_width(CSR_DATA_BITS'(cw));
         sent  = 0;
         broke = 1'b0;
         while (sent < RANDOM_PER_PHASE) begin
            len    = ($urandom_range(99) < 85) ? cw * cw : $urandom_range(cw * cw - 1, 1);
            flavor = $urandom_range(9);
            for (i = 0; i < len; i++) begin
               if (i == 0) begin
                  start = broke || (sent == 0) || ($urandom_range(1) == 1);
               end else begin
                  start = ($urandom_range(99) < 2);
               end
               send_sample(pick_sample(flavor), start);
            end
            broke = (len != cw * cw);
            sent += len;
         end
      end
      drain_results();
   endtask

   // hold the output off for a long stretch while samples keep coming
   task automatic test_output_hold_off();
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      write_width(32'd6);
      hold_ticket <= hold_ticket + 1;
      send_run(3 * 36, 2, 1'b1);
      drain_results();
   endtask

   // check each accepted mean word and drive the output stall
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_means.size() == 0) begin
            $error("mean word with nothing expected: mean %0d, last %0d",
                   rsp_word.mean, rsp_word.last);
            mismatch_count++;
         end else begin
            want = pending_means.pop_front();
            means_checked++;
            if (rsp_word.mean !== want.mean) begin
               $error("mean: expected %0d, got %0d", want.mean, rsp_word.mean);
               mismatch_count++;
            end
            if (rsp_word.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_word.last);
               mismatch_count++;
            end
         end
      end
      if (hold_ticket != hold_taken) begin
         hold_taken = hold_ticket;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (req_valid && req_stall) input_stall_cycles++;
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_psel && csr_penable)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      foreach (upper_row[i]) begin
         upper_row[i]  = '0;
         middle_row[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_extreme_samples();
      test_width_limits();
      test_width_shrink_mid_frame();
      test_random_frames();
      test_output_hold_off();
      drain_results();
      $display("Sent %0d samples and checked %0d means over full-scale, clamped and random frames,",
               samples_sent, means_checked);
      $display("with mid-frame width shrinks, a long output hold and %0d input stall cycles.",
               input_stall_cycles);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/bf3_pkg.sv
rtl/core/bf3_ram.sv
rtl/core/bf3_lines.sv
rtl/core/bf3_mean.sv
rtl/core/bf3_queue.sv
rtl/core/box_filter_3x3_stream.sv
tb/sv/tb_box_filter_3x3_stream.sv
